[sv/fvc_pkg.sv]
// Shared types, constants and helpers for the formant vowel classifier.
`timescale 1ns / 1ps
`default_nettype none
package fvc_pkg;

	localparam int SampleWidth = 16;
	localparam int CountWidth  = 6;
	localparam int F1HzWidth   = 10;
	localparam int F2HzWidth   = 12;

	localparam logic [CountWidth-1:0] MIN_BINS = 6'd60;
	localparam logic [CountWidth-1:0] F1_FIRST = 6'd4;
	localparam logic [CountWidth-1:0] F1_LAST  = 6'd17;
	localparam logic [CountWidth-1:0] F2_FIRST = 6'd18;
	localparam logic [CountWidth-1:0] F2_LAST  = 6'd49;

	localparam logic [SampleWidth-1:0] THRESHOLD_RESET = 16'd26;

	localparam logic [F1HzWidth-1:0] F1_LOW_IU  = 10'd250;
	localparam logic [F1HzWidth-1:0] F1_HIGH_IU = 10'd400;
	localparam logic [F1HzWidth-1:0] F1_LOW_A   = 10'd650;
	localparam logic [F1HzWidth-1:0] F1_HIGH_A  = 10'd850;
	localparam logic [F2HzWidth-1:0] F2_LOW_I   = 12'd2000;
	localparam logic [F2HzWidth-1:0] F2_HIGH_I  = 12'd2400;
	localparam logic [F2HzWidth-1:0] F2_LOW_A   = 12'd950;
	localparam logic [F2HzWidth-1:0] F2_HIGH_A  = 12'd1300;
	localparam logic [F2HzWidth-1:0] F2_LOW_U   = 12'd700;
	localparam logic [F2HzWidth-1:0] F2_HIGH_U  = 12'd950;

	typedef enum logic [2:0] {
		CLS_SILENT  = 3'd0,
		CLS_I       = 3'd1,
		CLS_A       = 3'd2,
		CLS_U       = 3'd3,
		CLS_UNKNOWN = 3'd4
	} vowel_class_t;

	typedef struct packed {
		vowel_class_t               cls;
		logic [F1HzWidth-1:0]       f1_hz;
		logic [F2HzWidth-1:0]       f2_hz;
	} result_t;

	// Bin index times 50 Hz: 32x + 16x + 2x.
	function automatic logic [F2HzWidth-1:0] bin_to_hz(input logic [CountWidth-1:0] idx);
		logic [F2HzWidth-1:0] x;
		x = {{(F2HzWidth-CountWidth){1'b0}}, idx};
		return (x << 5) + (x << 4) + (x << 1);
	endfunction

	function automatic vowel_class_t classify(input logic [F1HzWidth-1:0] f1,
			input logic [F2HzWidth-1:0] f2);
		logic f1_iu;
		logic f1_a;
		f1_iu = (f1 >= F1_LOW_IU) && (f1 <= F1_HIGH_IU);
		f1_a  = (f1 >= F1_LOW_A) && (f1 <= F1_HIGH_A);
		if (f1_iu && (f2 >= F2_LOW_I) && (f2 <= F2_HIGH_I))
			return CLS_I;
		if (f1_a && (f2 >= F2_LOW_A) && (f2 <= F2_HIGH_A))
			return CLS_A;
		if (f1_iu && (f2 >= F2_LOW_U) && (f2 <= F2_HIGH_U))
			return CLS_U;
		return CLS_UNKNOWN;
	endfunction

endpackage
`default_nettype wire

[sv/fvc_frame.sv]
// Input register, per-frame peak tracking and end-of-frame classification.
`timescale 1ns / 1ps
`default_nettype none
module fvc_frame (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wen,
	input  wire logic [fvc_pkg::SampleWidth-1:0]     cfg_wdata,
	input  wire logic                                bin_valid,
	output logic                                     bin_stall,
	input  wire logic [fvc_pkg::SampleWidth-1:0]     bin_value,
	input  wire logic                                last_bin,
	input  wire logic                                out_hold,
	output logic                                     res_load,
	output fvc_pkg::result_t                         res
);

	logic                                 valid_s1;
	logic [fvc_pkg::SampleWidth-1:0]      value_s1;
	logic                                 last_s1;

	logic [fvc_pkg::SampleWidth-1:0]      threshold_q;
	logic [fvc_pkg::CountWidth-1:0]       bin_counter_q;
	logic [fvc_pkg::SampleWidth-1:0]      peak1_value_q;
	logic [fvc_pkg::CountWidth-1:0]       peak1_index_q;
	logic [fvc_pkg::SampleWidth-1:0]      peak2_value_q;
	logic [fvc_pkg::CountWidth-1:0]       peak2_index_q;
	logic [fvc_pkg::F1HzWidth-1:0]        saved_f1_q;
	logic [fvc_pkg::F2HzWidth-1:0]        saved_f2_q;

	logic                                 advance;
	logic [fvc_pkg::CountWidth-1:0]       count_next;
	logic [fvc_pkg::SampleWidth-1:0]      p1v_next;
	logic [fvc_pkg::CountWidth-1:0]       p1i_next;
	logic [fvc_pkg::SampleWidth-1:0]      p2v_next;
	logic [fvc_pkg::CountWidth-1:0]       p2i_next;
	logic                                 short_frame;
	logic                                 silent;
	logic                                 store;
	logic [fvc_pkg::F2HzWidth-1:0]        f1_wide;
	logic [fvc_pkg::F1HzWidth-1:0]        f1_new;
	logic [fvc_pkg::F2HzWidth-1:0]        f2_new;

	assign advance   = valid_s1 && !(last_s1 && out_hold);
	assign bin_stall = valid_s1 && !advance;
	assign res_load  = advance && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!bin_stall) begin
			valid_s1 <= bin_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bin_valid && !bin_stall) begin
			value_s1 <= bin_value;
			last_s1  <= last_bin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= fvc_pkg::THRESHOLD_RESET;
		end else if (cfg_wen) begin
			threshold_q <= cfg_wdata;
		end
	end

	always_comb begin
		count_next = (bin_counter_q < fvc_pkg::MIN_BINS) ? bin_counter_q + 6'd1
			: fvc_pkg::MIN_BINS;
		p1v_next = peak1_value_q;
		p1i_next = peak1_index_q;
		p2v_next = peak2_value_q;
		p2i_next = peak2_index_q;
		if (bin_counter_q >= fvc_pkg::F1_FIRST && bin_counter_q <= fvc_pkg::F1_LAST
				&& value_s1 > peak1_value_q) begin
			p1v_next = value_s1;
			p1i_next = bin_counter_q;
		end
		if (bin_counter_q >= fvc_pkg::F2_FIRST && bin_counter_q <= fvc_pkg::F2_LAST
				&& value_s1 > peak2_value_q) begin
			p2v_next = value_s1;
			p2i_next = bin_counter_q;
		end
		short_frame = count_next < fvc_pkg::MIN_BINS;
		silent      = (p1v_next < threshold_q) || (p2v_next < threshold_q);
		store       = !short_frame && !silent;
		f1_wide     = fvc_pkg::bin_to_hz(p1i_next);
		f1_new      = f1_wide[fvc_pkg::F1HzWidth-1:0];
		f2_new      = fvc_pkg::bin_to_hz(p2i_next);
		res.f1_hz   = store ? f1_new : saved_f1_q;
		res.f2_hz   = store ? f2_new : saved_f2_q;
		if (short_frame)
			res.cls = fvc_pkg::CLS_UNKNOWN;
		else if (silent)
			res.cls = fvc_pkg::CLS_SILENT;
		else
			res.cls = fvc_pkg::classify(f1_new, f2_new);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_counter_q <= '0;
			peak1_value_q <= '0;
			peak1_index_q <= '0;
			peak2_value_q <= '0;
			peak2_index_q <= '0;
			saved_f1_q    <= '0;
			saved_f2_q    <= '0;
		end else if (advance) begin
			if (last_s1) begin
				bin_counter_q <= '0;
				peak1_value_q <= '0;
				peak1_index_q <= '0;
				peak2_value_q <= '0;
				peak2_index_q <= '0;
				if (store) begin
					saved_f1_q <= f1_new;
					saved_f2_q <= f2_new;
				end
			end else begin
				bin_counter_q <= count_next;
				peak1_value_q <= p1v_next;
				peak1_index_q <= p1i_next;
				peak2_value_q <= p2v_next;
				peak2_index_q <= p2i_next;
			end
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		bin_counter_q <= fvc_pkg::MIN_BINS)
		else $error("bin counter beyond saturation");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> (bin_counter_q == '0) && (peak1_value_q == '0) && (peak2_value_q == '0))
		else $error("frame state not cleared after last beat");

	assert property (@(posedge clk) disable iff (!arst_n)
		(peak1_index_q == '0)
		|| (peak1_index_q >= fvc_pkg::F1_FIRST && peak1_index_q <= fvc_pkg::F1_LAST))
		else $error("F1 peak index out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		(peak2_index_q == '0)
		|| (peak2_index_q >= fvc_pkg::F2_FIRST && peak2_index_q <= fvc_pkg::F2_LAST))
		else $error("F2 peak index out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1 && out_hold) |=> $stable(bin_counter_q))
		else $error("frame state moved while result blocked");
`endif

endmodule
`default_nettype wire

[sv/fvc_out.sv]
// Result register with valid/stall handshake toward the consumer.
`timescale 1ns / 1ps
`default_nettype none
module fvc_out (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            res_load,
	input  wire fvc_pkg::result_t                res,
	output logic                                 out_hold,
	output logic                                 res_valid,
	input  wire logic                            res_stall,
	output logic [2:0]                           vowel_class,
	output logic [fvc_pkg::F1HzWidth-1:0]        formant1_hz,
	output logic [fvc_pkg::F2HzWidth-1:0]        formant2_hz
);

	logic              res_valid_q;
	fvc_pkg::result_t  res_q;

	assign out_hold = res_valid_q && res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

	assign res_valid   = res_valid_q;
	assign vowel_class = res_q.cls;
	assign formant1_hz = res_q.f1_hz;
	assign formant2_hz = res_q.f2_hz;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> !out_hold)
		else $error("result overwritten while held");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> res_valid_q)
		else $error("loaded result not presented");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.cls == fvc_pkg::CLS_SILENT || res_q.cls == fvc_pkg::CLS_I
			|| res_q.cls == fvc_pkg::CLS_A || res_q.cls == fvc_pkg::CLS_U
			|| res_q.cls == fvc_pkg::CLS_UNKNOWN) && (res_q.f1_hz <= fvc_pkg::F1_HIGH_A))
		else $error("presented result outside its range");
`endif

endmodule
`default_nettype wire

[sv/formant_vowel_classifier_core.sv]
// Formant vowel classifier: top level joining frame tracking and result register.
// A last bin passes the input register and then the result register before its result shows.
// Throughput: one bin beat per cycle unless a last bin stalls; the input register
//   and result register let a new bin enter while a finished result waits to be taken.
// Only a last bin stalls, and only while the result register is full and stalled.
// Reset: arst_n clears the frame, the stored formants and both valids, and sets the
//   threshold to 26.
`timescale 1ns / 1ps
`default_nettype none
module formant_vowel_classifier_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wen,
	input  wire logic [fvc_pkg::SampleWidth-1:0] cfg_wdata,
	input  wire logic                            bin_valid,
	output logic                                 bin_stall,
	input  wire logic [fvc_pkg::SampleWidth-1:0] bin_value,
	input  wire logic                            last_bin,
	output logic                                 res_valid,
	input  wire logic                            res_stall,
	output logic [2:0]                           vowel_class,
	output logic [fvc_pkg::F1HzWidth-1:0]        formant1_hz,
	output logic [fvc_pkg::F2HzWidth-1:0]        formant2_hz
);

	logic              out_hold;
	logic              res_load;
	fvc_pkg::result_t  res;

	fvc_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.bin_valid (bin_valid),
		.bin_stall (bin_stall),
		.bin_value (bin_value),
		.last_bin  (last_bin),
		.out_hold  (out_hold),
		.res_load  (res_load),
		.res       (res)
	);

	fvc_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.res_load    (res_load),
		.res         (res),
		.out_hold    (out_hold),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.vowel_class (vowel_class),
		.formant1_hz (formant1_hz),
		.formant2_hz (formant2_hz)
	);

endmodule
`default_nettype wire
